/* hw/rtl/gfc_pkg.sv */
package gfc_pkg;

  // Channel and field sizes
  localparam int NCH_MAX      = 3;
  localparam int CHANNELS_DEF = 3;
  localparam int CODE_W       = 10;
  localparam int CNT_W        = 8;
  localparam int FLOOR_W      = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;

  // Register reset values
  localparam logic [CODE_W-1:0] DARK_BELOW_RST  = 10'd409;
  localparam logic [CODE_W-1:0] LIGHT_ABOVE_RST = 10'd410;
  localparam logic [CNT_W-1:0]  TICKS_RST       = 8'd16;
  localparam logic [CNT_W-1:0]  TIMEOUT_RST     = 8'd6;

  // Saturation ceiling of finger counts and idle units
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Digit weights of the reported floor value
  localparam logic [FLOOR_W-1:0] WEIGHT_HUNDREDS = 15'd100;
  localparam logic [FLOOR_W-1:0] WEIGHT_TENS     = 15'd10;

  typedef enum logic {
    OP_SWEEP = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_CLEARED = 2'd1,
    EV_REPORT  = 2'd2
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DARK_BELOW     = 2'd0,
    REG_LIGHT_ABOVE    = 2'd1,
    REG_TICKS_PER_UNIT = 2'd2,
    REG_TIMEOUT_UNITS  = 2'd3
  } cfg_reg_t;

  // Per-channel state after a sweep, before any end-of-entry clear
  typedef struct packed {
    logic             flag;
    logic [CNT_W-1:0] count;
    logic             touch;
  } chan_stat_t;

endpackage

/* hw/rtl/gfc_channel.sv */
module gfc_channel (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step_en,
  input  logic                      sweep,
  input  logic                      clear_entry,
  input  logic [gfc_pkg::CODE_W-1:0] code,
  input  logic [gfc_pkg::CODE_W-1:0] dark_below,
  input  logic [gfc_pkg::CODE_W-1:0] light_above,
  output gfc_pkg::chan_stat_t       stat
);
  import gfc_pkg::*;

  logic             in_sight;
  logic [CNT_W-1:0] count;

  // Detect a finger arriving or leaving on this sensor
  always_comb begin
    stat.flag  = in_sight;
    stat.count = count;
    stat.touch = 1'b0;
    if (sweep) begin
      if (!in_sight && (code < dark_below)) begin
        stat.flag  = 1'b1;
        stat.count = (count == CNT_MAX) ? count : count + 1'b1;
        stat.touch = 1'b1;
      end else if (in_sight && (code > light_above)) begin
        stat.flag  = 1'b0;
        stat.touch = 1'b1;
      end
    end
  end

  // Commit the step, or start a fresh entry
  always_ff @(posedge clk) begin
    if (rst) begin
      in_sight <= 1'b1;
      count    <= '0;
    end else if (step_en) begin
      if (clear_entry) begin
        in_sight <= 1'b1;
        count    <= '0;
      end else begin
        in_sight <= stat.flag;
        count    <= stat.count;
      end
    end
  end

endmodule

/* hw/rtl/gfc_idle_timer.sv */
module gfc_idle_timer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step_en,
  input  logic                     tick,
  input  logic                     touch,
  input  logic                     clear_entry,
  input  logic [gfc_pkg::CNT_W-1:0] ticks_per_unit,
  output logic [gfc_pkg::CNT_W-1:0] idle_upd
);
  import gfc_pkg::*;

  logic [CNT_W-1:0] tick_count;
  logic [CNT_W-1:0] tick_count_next;
  logic [CNT_W-1:0] tick_inc;
  logic [CNT_W-1:0] idle_units;

  // Advance the prescaler on a tick; restart idle time on sensor activity
  always_comb begin
    tick_inc        = tick_count + 1'b1;
    tick_count_next = tick_count;
    idle_upd        = idle_units;
    if (tick) begin
      if (tick_inc >= ticks_per_unit) begin
        tick_count_next = '0;
        idle_upd        = (idle_units == CNT_MAX) ? idle_units : idle_units + 1'b1;
      end else begin
        tick_count_next = tick_inc;
      end
    end else if (touch) begin
      idle_upd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      idle_units <= '0;
    end else if (step_en) begin
      tick_count <= tick_count_next;
      idle_units <= clear_entry ? '0 : idle_upd;
    end
  end

endmodule

/* hw/rtl/gesture_finger_counter_top.sv */
// Finger counter for a three-sensor gesture pad. Each input word is either a
// sample sweep (one 10-bit converter code per sensor) or a timer tick, and each
// one yields exactly one result word: the event code, the floor value when an
// entry is reported, and the three finger counts after the step. A word is
// registered on entry, worked through one short layer of compare and increment
// logic, and lands in an output register, so the block takes one word every
// cycle and offers each result from the output register; only the output
// side holding stall slows it. The user must write thresholds, ticks per
// idle unit and the timeout through the configuration port while the block
// is idle, which the block does not enforce; that port is always ready.
module gesture_finger_counter_top #(
  parameter int CHANNELS = gfc_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [gfc_pkg::CODE_W-1:0]     sample_0,
  input  logic [gfc_pkg::CODE_W-1:0]     sample_1,
  input  logic [gfc_pkg::CODE_W-1:0]     sample_2,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    event_res,
  output logic [gfc_pkg::FLOOR_W-1:0]    floor_value,
  output logic [gfc_pkg::CNT_W-1:0]      count_0,
  output logic [gfc_pkg::CNT_W-1:0]      count_1,
  output logic [gfc_pkg::CNT_W-1:0]      count_2,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gfc_pkg::*;

  // Configuration registers
  logic [CODE_W-1:0] dark_below;
  logic [CODE_W-1:0] light_above;
  logic [CNT_W-1:0]  ticks_per_unit;
  logic [CNT_W-1:0]  timeout_units;

  // Input register
  logic              in_q_valid;
  op_t               in_q_op;
  logic [CODE_W-1:0] in_q_code [NCH_MAX];

  // Step control
  logic              advance;
  logic              step_en;
  logic              sweep;
  logic              any_flag;
  logic              touch_any;
  logic              clear_entry;
  logic [CNT_W-1:0]  idle_upd;
  chan_stat_t        stat [NCH_MAX];
  logic [CNT_W-1:0]  count_after [NCH_MAX];
  event_t            event_next;
  logic [FLOOR_W-1:0] floor_next;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dark_below     <= DARK_BELOW_RST;
      light_above    <= LIGHT_ABOVE_RST;
      ticks_per_unit <= TICKS_RST;
      timeout_units  <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DARK_BELOW:     dark_below     <= cfg_data;
        REG_LIGHT_ABOVE:    light_above    <= cfg_data;
        REG_TICKS_PER_UNIT: ticks_per_unit <= cfg_data[CNT_W-1:0];
        REG_TIMEOUT_UNITS:  timeout_units  <= cfg_data[CNT_W-1:0];
        default:            ;
      endcase
    end
  end

  // Handshake: the step fires when the output register is free or draining
  assign advance  = !out_valid || !out_stall;
  assign step_en  = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_op      <= op_t'(opcode);
      in_q_code[0] <= sample_0;
      in_q_code[1] <= sample_1;
      in_q_code[2] <= sample_2;
    end
  end

  assign sweep = (in_q_op == OP_SWEEP);

  // Sensor channels; unused ones hold a zero count and no flag
  for (genvar j = 0; j < NCH_MAX; j++) begin : g_chan
    if (j < CHANNELS) begin : g_used
      gfc_channel u_channel (
        .clk         (clk),
        .rst         (rst),
        .step_en     (step_en),
        .sweep       (sweep),
        .clear_entry (clear_entry),
        .code        (in_q_code[j]),
        .dark_below  (dark_below),
        .light_above (light_above),
        .stat        (stat[j])
      );
    end else begin : g_unused
      assign stat[j] = '0;
    end
    assign count_after[j] = clear_entry ? '0 : stat[j].count;
  end

  // Combine channel activity
  always_comb begin
    any_flag  = 1'b0;
    touch_any = 1'b0;
    for (int j = 0; j < NCH_MAX; j++) begin
      any_flag  = any_flag  | stat[j].flag;
      touch_any = touch_any | stat[j].touch;
    end
  end

  gfc_idle_timer u_idle_timer (
    .clk            (clk),
    .rst            (rst),
    .step_en        (step_en),
    .tick           (!sweep),
    .touch          (touch_any),
    .clear_entry    (clear_entry),
    .ticks_per_unit (ticks_per_unit),
    .idle_upd       (idle_upd)
  );

  // End the entry after a sweep once idle time passes the timeout
  assign clear_entry = sweep && (idle_upd > timeout_units);

  always_comb begin
    event_next = EV_NONE;
    floor_next = '0;
    if (clear_entry) begin
      if (any_flag) begin
        event_next = EV_REPORT;
        floor_next = FLOOR_W'(stat[2].count) * WEIGHT_HUNDREDS
                   + FLOOR_W'(stat[1].count) * WEIGHT_TENS
                   + FLOOR_W'(stat[0].count);
      end else begin
        event_next = EV_CLEARED;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      event_res   <= event_next;
      floor_value <= floor_next;
      count_0     <= count_after[0];
      count_1     <= count_after[1];
      count_2     <= count_after[2];
    end
  end

endmodule

/* hw/rtl/gfc_checker.sv */
module gfc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    event_res,
  input logic [gfc_pkg::FLOOR_W-1:0]    floor_value,
  input logic [gfc_pkg::CNT_W-1:0]      count_0,
  input logic [gfc_pkg::CNT_W-1:0]      count_1,
  input logic [gfc_pkg::CNT_W-1:0]      count_2
);
  import gfc_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(floor_value)
      && $stable(count_0) && $stable(count_1) && $stable(count_2))
    else $error("stalled result word changed");

  // An ended entry shows cleared counts
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res != EV_NONE) |-> (count_0 == '0) && (count_1 == '0)
      && (count_2 == '0))
    else $error("counts not cleared at end of entry");

  // Floor value only accompanies a report
  a_floor_only_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res != EV_REPORT) |-> floor_value == '0)
    else $error("floor value without report");

  // No result word right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word offered after reset");

  // An idle input side with an empty pipe cannot stall
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_valid |=> !in_stall || $past(in_valid))
    else $error("input stalled with nothing in flight");

endmodule

bind gesture_finger_counter_top gfc_checker u_gfc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .event_res   (event_res),
  .floor_value (floor_value),
  .count_0     (count_0),
  .count_1     (count_1),
  .count_2     (count_2)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import gfc_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 5;
  localparam int IDLE_PCT        = 37;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 8;

  // One result word as the block presents it
  typedef struct packed {
    event_t             ev;
    logic [FLOOR_W-1:0] floor_val;
    logic [CNT_W-1:0]   c0;
    logic [CNT_W-1:0]   c1;
    logic [CNT_W-1:0]   c2;
  } result_word_t;

  // Finger counter predictor and store of pending result words
  class finger_scoreboard;
    bit [CODE_W-1:0] dark_below;
    bit [CODE_W-1:0] light_above;
    bit [CNT_W-1:0]  ticks_per_unit;
    bit [CNT_W-1:0]  timeout_units;
    bit [NCH_MAX-1:0] in_sight;
    bit [CNT_W-1:0]  cnt [NCH_MAX];
    bit [CNT_W-1:0]  tick_cnt;
    bit [CNT_W-1:0]  idle_units;
    result_word_t    pending_q [$];
    int errors;
    int results_checked;
    int reports;
    int clears;

    function new();
      dark_below     = DARK_BELOW_RST;
      light_above    = LIGHT_ABOVE_RST;
      ticks_per_unit = TICKS_RST;
      timeout_units  = TIMEOUT_RST;
      tick_cnt       = '0;
      clear_entry();
    endfunction

    // Drop the counts, raise every flag, restart idle time
    function void clear_entry();
      int j;
      for (j = 0; j < NCH_MAX; j++) cnt[j] = '0;
      in_sight   = '1;
      idle_units = '0;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DARK_BELOW:     dark_below     = data[CODE_W-1:0];
        REG_LIGHT_ABOVE:    light_above    = data[CODE_W-1:0];
        REG_TICKS_PER_UNIT: ticks_per_unit = data[CNT_W-1:0];
        REG_TIMEOUT_UNITS:  timeout_units  = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the predicted state by one accepted word and queue its result
    function void note_word(op_t op, bit [CODE_W-1:0] s0, bit [CODE_W-1:0] s1,
                            bit [CODE_W-1:0] s2);
      bit [CODE_W-1:0] code [NCH_MAX];
      result_word_t w;
      int j;
      code[0] = s0;
      code[1] = s1;
      code[2] = s2;
      w.ev = EV_NONE;
      w.floor_val = '0;
      if (op == OP_TICK) begin
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt >= ticks_per_unit) begin
          tick_cnt = '0;
          if (idle_units != CNT_MAX) idle_units = idle_units + 8'd1;
        end
      end else begin
        for (j = 0; j < NCH_MAX; j++) begin
          if (!in_sight[j] && code[j] < dark_below) begin
            if (cnt[j] != CNT_MAX) cnt[j] = cnt[j] + 8'd1;
            idle_units  = '0;
            in_sight[j] = 1'b1;
          end else if (in_sight[j] && code[j] > light_above) begin
            idle_units  = '0;
            in_sight[j] = 1'b0;
          end
        end
        // End the entry once idle time is past the timeout
        if (idle_units > timeout_units) begin
          if (|in_sight) begin
            w.ev = EV_REPORT;
            w.floor_val = FLOOR_W'(100 * int'(cnt[2]) + 10 * int'(cnt[1]) + int'(cnt[0]));
          end else begin
            w.ev = EV_CLEARED;
          end
          clear_entry();
        end
      end
      w.c0 = cnt[0];
      w.c1 = cnt[1];
      w.c2 = cnt[2];
      pending_q.push_back(w);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare one result word with the oldest pending one
    function void check_word(event_t ev, bit [FLOOR_W-1:0] fv, bit [CNT_W-1:0] c0,
                             bit [CNT_W-1:0] c1, bit [CNT_W-1:0] c2);
      result_word_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing pending: expected none, actual event %0d",
                 $time, ev);
        return;
      end
      want = pending_q.pop_front();
      results_checked++;
      compare_field("event_res", want.ev, ev);
      compare_field("floor_value", want.floor_val, fv);
      compare_field("count_0", want.c0, c0);
      compare_field("count_1", want.c1, c1);
      compare_field("count_2", want.c2, c2);
      if (want.ev == EV_REPORT) reports++;
      else if (want.ev == EV_CLEARED) clears++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_SWEEP;
  logic [CODE_W-1:0] sample_0 = '0;
  logic [CODE_W-1:0] sample_1 = '0;
  logic [CODE_W-1:0] sample_2 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] event_res;
  logic [FLOOR_W-1:0] floor_value;
  logic [CNT_W-1:0] count_0;
  logic [CNT_W-1:0] count_1;
  logic [CNT_W-1:0] count_2;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  finger_scoreboard sb = new();
  int  quiet_cycles = 0;
  int  words_sent = 0;
  int  cfg_writes = 0;
  bit  idle_on = 1'b1;
  bit  holdoff_req = 1'b0;

  gesture_finger_counter_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .sample_0(sample_0),
    .sample_1(sample_1),
    .sample_2(sample_2),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_res(event_res),
    .floor_value(floor_value),
    .count_0(count_0),
    .count_1(count_1),
    .count_2(count_2),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Sample both channels at the rising edge; count cycles with no progress
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall)
        sb.note_word(op_t'(opcode), sample_0, sample_1, sample_2);
      if (out_valid && !out_stall)
        sb.check_word(event_t'(event_res), floor_value, count_0, count_1, count_2);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("tb failed");
    $finish;
  end

  // Result side: random stall, or one long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Offer one word and hold it until accepted; return at a falling edge
  task automatic drive_word(op_t op, int c0, int c1, int c2);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    sample_0 <= CODE_W'(c0);
    sample_1 <= CODE_W'(c1);
    sample_2 <= CODE_W'(c2);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Code that leaves channel j as it is
  function automatic int steady_code(int j);
    if (sb.in_sight[j]) return $urandom_range(int'(sb.light_above), 0);
    return $urandom_range(1023, int'(sb.dark_below));
  endfunction

  // Code that uncovers a sensor
  function automatic int lift_code(int j);
    if (sb.light_above == 10'd1023) return steady_code(j);
    return $urandom_range(1023, int'(sb.light_above) + 1);
  endfunction

  // Code that covers a sensor
  function automatic int cover_code(int j);
    if (sb.dark_below == 10'd0) return steady_code(j);
    return $urandom_range(int'(sb.dark_below) - 1, 0);
  endfunction

  // Sweep with the channels in lift uncovered, those in cover_mask covered, rest held
  task automatic sweep_masked(int lift, int cover_mask);
    int code [NCH_MAX];
    int j;
    for (j = 0; j < NCH_MAX; j++) begin
      if (lift[j]) code[j] = lift_code(j);
      else if (cover_mask[j]) code[j] = cover_code(j);
      else code[j] = steady_code(j);
    end
    drive_word(OP_SWEEP, code[0], code[1], code[2]);
  endtask

  task automatic tick_word();
    drive_word(OP_TICK, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
  endtask

  task automatic noise_word();
    drive_word(op_t'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
               $urandom_range(1023));
  endtask

  // Stop offering and wait until every pending result word is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, CFG_DATA_W'(data));
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_cfg(int dark, int light, int tpu, int tmo);
    drain();
    write_reg(REG_DARK_BELOW, dark);
    write_reg(REG_LIGHT_ABOVE, light);
    write_reg(REG_TICKS_PER_UNIT, tpu);
    write_reg(REG_TIMEOUT_UNITS, tmo);
  endtask

  // Finger entries: gestures, idle ticks, a closing sweep; some noise and cut-short entries
  task automatic run_entries(int n_words);
    int start_cnt;
    int fingers;
    int mask;
    int nt;
    int k;
    start_cnt = words_sent;
    while (words_sent - start_cnt < n_words) begin
      fingers = $urandom_range(4, 0);
      for (k = 0; k < fingers; k++) begin
        mask = $urandom_range(7, 1);
        sweep_masked(mask, 0);
        sweep_masked(0, mask);
        if ($urandom_range(99) < 15) noise_word();
      end
      if ($urandom_range(99) < 25) sweep_masked($urandom_range(7, 1), 0);
      nt = (int'(sb.timeout_units) + 1) * (sb.ticks_per_unit == 0 ? 1 : int'(sb.ticks_per_unit));
      if ($urandom_range(99) < 10) nt = $urandom_range(nt / 2);
      else nt = nt + $urandom_range(2);
      for (k = 0; k < nt; k++) begin
        if ($urandom_range(99) < 8) sweep_masked(0, 0);
        else tick_word();
      end
      sweep_masked(0, 0);
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: threshold edges, extreme codes, tick without ending an entry
    tick_word();
    drive_word(OP_SWEEP, 1023, 1023, 1023);
    drive_word(OP_SWEEP, 0, 0, 0);
    drive_word(OP_SWEEP, 410, 410, 410);
    drive_word(OP_SWEEP, 411, 411, 411);
    drive_word(OP_SWEEP, 409, 409, 409);
    drive_word(OP_SWEEP, 408, 1023, 1023);
    drive_word(OP_SWEEP, 682, 341, 341);
    drive_word(OP_SWEEP, 0, 1023, 682);
    tick_word();
    tick_word();
    tick_word();
    drive_word(OP_SWEEP, 341, 682, 682);

    // Directed: zero ticks per unit, report, then cleared entry
    apply_cfg(409, 410, 0, 0);
    tick_word();
    tick_word();
    tick_word();
    drive_word(OP_SWEEP, 0, 1023, 1023);
    drive_word(OP_SWEEP, 1023, 1023, 1023);
    tick_word();
    drive_word(OP_SWEEP, 682, 682, 682);
    tick_word();
    tick_word();
    drive_word(OP_SWEEP, 1023, 0, 1023);
    apply_cfg(DARK_BELOW_RST, LIGHT_ABOVE_RST, TICKS_RST, TIMEOUT_RST);

    // Random entries on the reset setting
    run_entries(100);
    // No code covers and none uncovers
    apply_cfg(0, 1023, 0, 0);
    run_entries(30);
    // Inverted thresholds
    apply_cfg(1023, 0, 1, 1);
    run_entries(30);

    // Saturate counts and idle units with no idling at all
    apply_cfg(300, 700, 0, 255);
    idle_on = 1'b0;
    for (k = 0; k < 256; k++) begin
      sweep_masked(7, 0);
      sweep_masked(0, 7);
    end
    for (k = 0; k < 258; k++) tick_word();
    sweep_masked(0, 0);
    drain();
    write_reg(REG_TIMEOUT_UNITS, 254);
    sweep_masked(0, 0);
    idle_on = 1'b1;

    // Hold off the result side while words keep coming
    apply_cfg(512, 512, 3, 2);
    holdoff_req = 1'b1;
    run_entries(60);

    apply_cfg(200, 800, 2, 5);
    run_entries(40);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d result words never arrived", $time, sb.pending_q.size());
    end
    $display("Sent %0d words over %0d register writes; checked %0d results",
             words_sent, cfg_writes, sb.results_checked);
    $display("Entries reported %0d, cleared %0d; mismatches %0d",
             sb.reports, sb.clears, sb.errors);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
